// ===== rtl/core/i2c_bit_level_master_defines.svh =====
// Assertion macros shared by the bit-level I2C master RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef I2C_BIT_LEVEL_MASTER_DEFINES_SVH
`define I2C_BIT_LEVEL_MASTER_DEFINES_SVH

// Clocked check, off while reset is held.
`define I2CM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Clocked check that also holds during reset.
`define I2CM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/i2cm_pkg.sv =====
// Shared types and constants for the bit-level I2C master.
// No dependencies; imported by i2cm_seq and i2c_bit_level_master.
`default_nettype none

package i2cm_pkg;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4,
        CMD_ACK   = 3'd5,
        CMD_NACK  = 3'd6
    } t_cmd;

    localparam int UNIT_W     = 16;
    localparam int TICK_W     = UNIT_W + 1;
    localparam int OUT_DATA_W = 16;
    localparam int IN_DATA_W  = 16;
    localparam int APB_ADDR_W = 2;

    localparam logic [UNIT_W-1:0]     TPU_RESET = 16'd50;
    localparam logic [APB_ADDR_W-1:0] REG_TPU   = 2'd0;

    // One tick's outcome, from the sequencer to the output stage.
    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic       read_valid;
        logic [7:0] read_byte;
    } t_seq_res;

endpackage

`default_nettype wire

// ===== rtl/core/i2c_bit_level_master.sv =====
// Top level of the bit-level I2C master: APB register, input stream, output skid stage.
// Depends on i2cm_pkg, i2cm_seq and i2c_bit_level_master_defines.svh.
//
//   channel   direction  handshake               payload
//   s_axis    in         tvalid/tready           tuser: req_type; tdata: wr_byte, sda_in
//   m_axis    out        tvalid/tready           tdata: scl, sda, busy, done, rd_valid, byte
//   apb       in/out     psel/penable/pready     ticks_per_unit at byte address 0
//
// Each input transfer is one bus tick; the sequencer updates its state in the
// cycle of the transfer, so one transfer is taken per clock cycle while the
// skid stage is empty. The result is registered in the output register.
// A stalled output fills a one-entry skid stage; s_axis_tready drops only then.
// Reset is synchronous: lines released high, sequencer idle, unit length 50.
`default_nettype none
`include "i2c_bit_level_master_defines.svh"

module i2c_bit_level_master
    import i2cm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input stream
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // [7:0] wr_byte, [8] sda_in
    input  wire logic [2:0]            s_axis_tuser,  // [2:0] req_type
    // output stream
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // [0] scl_out, [1] sda_out, [2] busy_res,
                                                      // [3] done_res, [4] read_valid,
                                                      // [12:5] read_byte
    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic [UNIT_W-1:0] r_tpu;
    logic              r_out_valid;
    t_seq_res          r_out;
    logic              r_skid_valid;
    t_seq_res          r_skid;
    t_seq_res          res;
    logic              in_xfer;
    logic              out_xfer;

    // ---- configuration register ----
    assign pready = 1'b1;
    assign prdata = (paddr == REG_TPU) ? {16'd0, r_tpu} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpu <= TPU_RESET;
        end else if (psel && penable && pwrite && pready && paddr == REG_TPU) begin
            r_tpu <= pwdata[UNIT_W-1:0];
        end
    end

    // ---- sequencer: one tick per accepted transfer ----
    assign s_axis_tready = !r_skid_valid;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_xfer      = r_out_valid && m_axis_tready;

    i2cm_seq u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (in_xfer),
        .i_req_type       (s_axis_tuser),
        .i_wr_byte        (s_axis_tdata[7:0]),
        .i_sda_in         (s_axis_tdata[8]),
        .i_ticks_per_unit (r_tpu),
        .o_res            (res)
    );

    // ---- output register with skid ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_xfer || !r_out_valid) begin
            // output slot frees: drain skid first, else take the new result
            r_out_valid  <= r_skid_valid || in_xfer;
            r_skid_valid <= 1'b0;
        end else if (in_xfer) begin
            // output held: park the new result
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_xfer || !r_out_valid) begin
            r_out <= r_skid_valid ? r_skid : res;
        end
        if (in_xfer && r_out_valid && !out_xfer) begin
            r_skid <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'd0, r_out.read_byte, r_out.read_valid, r_out.done,
                            r_out.busy, r_out.sda, r_out.scl};

    `I2CM_ASSERT(a_skid_needs_out, (!r_skid_valid) || r_out_valid, "skid full, output empty")
    `I2CM_ASSERT(a_skid_hold, (r_skid_valid && !m_axis_tready) |=> r_skid_valid, "skid lost")
    `I2CM_ASSERT(a_out_hold, (r_out_valid && !m_axis_tready) |=> $stable(r_out), "output changed")

endmodule

`default_nettype wire

// ===== rtl/core/i2cm_seq.sv =====
// Bus sequencer of the bit-level I2C master: command state, segment timer, line levels.
// Depends on i2cm_pkg and i2c_bit_level_master_defines.svh.
`default_nettype none
`include "i2c_bit_level_master_defines.svh"

module i2cm_seq
    import i2cm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [2:0]        i_req_type,
    input  wire logic [7:0]        i_wr_byte,
    input  wire logic              i_sda_in,
    input  wire logic [UNIT_W-1:0] i_ticks_per_unit,
    output t_seq_res               o_res
);

    typedef struct packed {
        logic              scl;
        logic              sda;
        logic [TICK_W-1:0] tick;
    } t_seg;

    t_cmd              r_cmd,   n_cmd;
    logic [1:0]        r_phase, n_phase;
    logic [TICK_W-1:0] r_tick,  n_tick;
    logic [3:0]        r_bit,   n_bit;
    logic [7:0]        r_shift, n_shift;
    logic              r_scl,   n_scl;
    logic              r_sda,   n_sda;

    logic [UNIT_W-1:0] unit;
    logic [TICK_W-1:0] tick_dec;
    logic [1:0]        phase_inc;
    logic              phase_more;
    logic              finished;
    logic              done;
    logic              rd_valid;
    logic [7:0]        rd_byte;
    t_seg              seg;

    // Line levels and length for the segment that phase ph opens.
    function automatic t_seg seg_enter(
        input t_cmd              c,
        input logic [1:0]        ph,
        input logic [3:0]        bi,
        input logic [7:0]        sh,
        input logic              scl,
        input logic              sda,
        input logic [UNIT_W-1:0] u
    );
        t_seg s;
        s.scl  = scl;
        s.sda  = sda;
        s.tick = {u, 1'b0};
        case (c)
            CMD_START, CMD_STOP: begin
                if (ph == 2'd0) begin
                    s.scl = 1'b1;
                    s.sda = (c == CMD_START);
                end else begin
                    s.sda = (c == CMD_STOP);
                end
            end
            CMD_READ: begin
                if (ph == 2'd0) begin
                    s.sda = 1'b1;
                    s.scl = 1'b0;
                end else begin
                    s.scl  = 1'b1;
                    s.tick = {1'b0, u};
                end
            end
            default: begin
                if (ph == 2'd0) begin
                    if (c == CMD_WRITE) begin
                        s.sda = (bi < 4'd8) ? sh[7] : 1'b1;
                    end else begin
                        s.sda = (c == CMD_NACK);
                    end
                    s.scl = 1'b0;
                end else begin
                    s.scl = 1'b1;
                end
            end
        endcase
        return s;
    endfunction

    assign unit      = (i_ticks_per_unit == '0) ? UNIT_W'(1) : i_ticks_per_unit;
    assign tick_dec  = (r_tick != '0) ? r_tick - TICK_W'(1) : '0;
    assign phase_inc = r_phase + 2'd1;
    assign phase_more = (r_cmd == CMD_READ) ? (phase_inc < 2'd3) : (phase_inc < 2'd2);

    always_comb begin
        n_cmd    = r_cmd;
        n_phase  = r_phase;
        n_tick   = r_tick;
        n_bit    = r_bit;
        n_shift  = r_shift;
        n_scl    = r_scl;
        n_sda    = r_sda;
        finished = 1'b0;
        done     = 1'b0;
        rd_valid = 1'b0;
        rd_byte  = '0;
        seg      = '0;
        if (r_cmd == CMD_NONE) begin
            if (i_req_type inside {[CMD_START:CMD_NACK]}) begin
                n_cmd   = t_cmd'(i_req_type);
                n_phase = 2'd0;
                n_bit   = 4'd0;
                n_shift = (i_req_type == CMD_WRITE) ? i_wr_byte : 8'd0;
                seg     = seg_enter(n_cmd, 2'd0, 4'd0, n_shift, r_scl, r_sda, unit);
                n_scl   = seg.scl;
                n_sda   = seg.sda;
                n_tick  = seg.tick;
            end
        end else begin
            n_tick = tick_dec;
            if (tick_dec == '0) begin
                if (phase_more) begin
                    n_phase = phase_inc;
                    seg     = seg_enter(r_cmd, phase_inc, r_bit, r_shift, r_scl, r_sda, unit);
                    n_scl   = seg.scl;
                    n_sda   = seg.sda;
                    n_tick  = seg.tick;
                    // sample one unit into the high time
                    if (r_cmd == CMD_READ && phase_inc == 2'd2) begin
                        n_shift = {r_shift[6:0], i_sda_in};
                    end
                end else begin
                    n_scl    = 1'b0;
                    finished = 1'b1;
                    if (r_cmd == CMD_WRITE) begin
                        n_shift  = {r_shift[6:0], 1'b0};
                        n_bit    = r_bit + 4'd1;
                        finished = (n_bit >= 4'd9);
                    end else if (r_cmd == CMD_READ) begin
                        n_bit    = r_bit + 4'd1;
                        finished = (n_bit >= 4'd8);
                        rd_valid = finished;
                        rd_byte  = finished ? r_shift : 8'd0;
                    end
                    if (finished) begin
                        done    = 1'b1;
                        n_cmd   = CMD_NONE;
                        n_phase = 2'd0;
                        n_tick  = '0;
                    end else begin
                        n_phase = 2'd0;
                        seg     = seg_enter(r_cmd, 2'd0, n_bit, n_shift, n_scl, r_sda, unit);
                        n_scl   = seg.scl;
                        n_sda   = seg.sda;
                        n_tick  = seg.tick;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd   <= CMD_NONE;
            r_phase <= 2'd0;
            r_tick  <= '0;
            r_bit   <= 4'd0;
            r_shift <= 8'd0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
        end else if (i_step) begin
            r_cmd   <= n_cmd;
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
        end
    end

    assign o_res.scl        = n_scl;
    assign o_res.sda        = n_sda;
    assign o_res.busy       = (n_cmd != CMD_NONE);
    assign o_res.done       = done;
    assign o_res.read_valid = rd_valid;
    assign o_res.read_byte  = rd_byte;

    `I2CM_ASSERT(a_idle_timer_clear, (r_cmd != CMD_NONE) || (r_tick == '0), "idle timer running")
    `I2CM_ASSERT(a_valid_ends_read, o_res.read_valid |-> (o_res.done && r_cmd == CMD_READ), "bad rd")
    `I2CM_ASSERT(a_write_bits, (r_cmd != CMD_WRITE) || (r_bit <= 4'd8), "write past ninth pulse")
    `I2CM_ASSERT(a_phase_range, (r_cmd == CMD_READ) || (r_phase != 2'd2), "third phase outside read")

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking bench for i2c_bit_level_master: each tick goes in on s_axis and an in-house
// tick model predicts the line levels, busy, done and read byte for every m_axis transfer.
// Depends on i2cm_pkg and the i2c_bit_level_master RTL; needs no files or arguments.
`timescale 1ns / 100ps

module testbench;
    import i2cm_pkg::*;

    // Code 7 is not a command; the master drops it like an idle tick.
    localparam logic [2:0] REQ_UNUSED   = 3'd7;
    localparam int         GAP_MAX      = 16;
    localparam int         HOLD_CYCLES  = 200;
    localparam int         IDLE_LIMIT   = 2000;
    localparam int         RANDOM_ITEMS = 60;
    localparam int         REPORT_MAX   = 10;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // [7:0] wr_byte, [8] sda_in
    logic [2:0]            s_axis_tuser;   // [2:0] req_type
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // [0] scl, [1] sda, [2] busy, [3] done,
                                           // [4] read_valid, [12:5] read_byte
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    // Sequencer state as the bus sees it, advanced once per accepted tick.
    typedef struct packed {
        t_cmd        cmd;
        logic [3:0]  phase;
        logic [17:0] ticks;
        logic [3:0]  bit_idx;
        logic [7:0]  shreg;
        logic        scl;
        logic        sda;
    } t_bus_state;

    // What one tick drives onto m_axis.
    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic       rd_valid;
        logic [7:0] rd_byte;
    } t_tick_lines;

    t_bus_state  bus;
    logic [15:0] unit_len_reg;
    t_tick_lines expected_lines[$];

    bit tx_gaps_on;
    bit rx_gaps_on;
    int rx_hold_cycles;
    int items_sent;
    int results_seen;
    int mismatches;
    int idle_cycles;

    i2c_bit_level_master u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Tick model
    // ------------------------------------------------------------------

    // Segment length in ticks; a unit length of zero counts as one tick.
    function automatic logic [17:0] unit_ticks(input int unsigned mult);
        int unsigned u;
        u = (unit_len_reg == 16'd0) ? 1 : unit_len_reg;
        return 18'(mult * u);
    endfunction

    // Drive the lines for the current phase and load its length.
    function automatic void load_segment();
        case (bus.cmd)
            CMD_START, CMD_STOP: begin
                if (bus.phase == 4'd0) begin
                    bus.scl = 1'b1;
                    bus.sda = (bus.cmd == CMD_START);
                end else begin
                    bus.sda = (bus.cmd == CMD_STOP);
                end
                bus.ticks = unit_ticks(2);
            end
            CMD_READ: begin
                if (bus.phase == 4'd0) begin
                    bus.sda   = 1'b1;
                    bus.scl   = 1'b0;
                    bus.ticks = unit_ticks(2);
                end else begin
                    // high time splits in two halves around the sample point
                    bus.scl   = 1'b1;
                    bus.ticks = unit_ticks(1);
                end
            end
            default: begin
                if (bus.phase == 4'd0) begin
                    if (bus.cmd == CMD_WRITE) begin
                        // ninth pulse releases SDA for the (unsampled) acknowledge
                        bus.sda = (bus.bit_idx < 4'd8) ? bus.shreg[7] : 1'b1;
                    end else begin
                        bus.sda = (bus.cmd == CMD_NACK);
                    end
                    bus.scl = 1'b0;
                end else begin
                    bus.scl = 1'b1;
                end
                bus.ticks = unit_ticks(2);
            end
        endcase
    endfunction

    // Advance the model by one tick and return what the master should drive.
    function automatic t_tick_lines tick_bus(input logic [2:0] req, input logic [7:0] wr,
                                             input logic sda_in);
        t_tick_lines r;
        logic        finished;
        logic [3:0]  last_phase;
        r = '0;
        if (bus.cmd == CMD_NONE) begin
            if (req >= CMD_START && req <= CMD_NACK) begin
                bus.cmd     = t_cmd'(req);
                bus.phase   = 4'd0;
                bus.bit_idx = 4'd0;
                bus.shreg   = (req == CMD_WRITE) ? wr : 8'h00;
                load_segment();
            end
        end else begin
            if (bus.ticks != 18'd0) bus.ticks = bus.ticks - 18'd1;
            if (bus.ticks == 18'd0) begin
                bus.phase  = bus.phase + 4'd1;
                last_phase = (bus.cmd == CMD_READ) ? 4'd3 : 4'd2;
                if (bus.phase < last_phase) begin
                    load_segment();
                    // sample SDA one unit into the high time
                    if (bus.cmd == CMD_READ && bus.phase == 4'd2) begin
                        bus.shreg = {bus.shreg[6:0], sda_in};
                    end
                end else begin
                    finished = 1'b1;
                    bus.scl  = 1'b0;
                    if (bus.cmd == CMD_WRITE) begin
                        bus.shreg   = {bus.shreg[6:0], 1'b0};
                        bus.bit_idx = bus.bit_idx + 4'd1;
                        finished    = (bus.bit_idx >= 4'd9);
                    end else if (bus.cmd == CMD_READ) begin
                        bus.bit_idx = bus.bit_idx + 4'd1;
                        finished    = (bus.bit_idx >= 4'd8);
                        if (finished) begin
                            r.rd_valid = 1'b1;
                            r.rd_byte  = bus.shreg;
                        end
                    end
                    if (finished) begin
                        r.done    = 1'b1;
                        bus.cmd   = CMD_NONE;
                        bus.phase = 4'd0;
                        bus.ticks = 18'd0;
                    end else begin
                        // next bit starts on the same tick SCL drops
                        bus.phase = 4'd0;
                        load_segment();
                    end
                end
            end
        end
        r.scl  = bus.scl;
        r.sda  = bus.sda;
        r.busy = (bus.cmd != CMD_NONE);
        return r;
    endfunction

    // Look one idle tick ahead without disturbing the model.
    function automatic logic finishes_next();
        t_bus_state  saved;
        t_tick_lines r;
        saved = bus;
        r     = tick_bus(CMD_NONE, 8'h00, 1'b0);
        bus   = saved;
        return r.done;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    function automatic void note_mismatch(input string field, input int unsigned want,
                                          input int unsigned got);
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
            $display("mismatch in %s at result %0d: expected 0x%0h, got 0x%0h",
                     field, results_seen, want, got);
        end
    endfunction

    // Compare every m_axis transfer against the oldest predicted tick.
    always @(posedge i_clk) begin : check_results
        t_tick_lines want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_lines.size() == 0) begin
                note_mismatch("unexpected result", 0, m_axis_tdata);
            end else begin
                want = expected_lines.pop_front();
                if (m_axis_tdata[0] !== want.scl)
                    note_mismatch("scl_out", want.scl, m_axis_tdata[0]);
                if (m_axis_tdata[1] !== want.sda)
                    note_mismatch("sda_out", want.sda, m_axis_tdata[1]);
                if (m_axis_tdata[2] !== want.busy)
                    note_mismatch("busy_res", want.busy, m_axis_tdata[2]);
                if (m_axis_tdata[3] !== want.done)
                    note_mismatch("done_res", want.done, m_axis_tdata[3]);
                if (m_axis_tdata[4] !== want.rd_valid)
                    note_mismatch("read_valid", want.rd_valid, m_axis_tdata[4]);
                if (m_axis_tdata[12:5] !== want.rd_byte)
                    note_mismatch("read_byte", want.rd_byte, m_axis_tdata[12:5]);
            end
            results_seen++;
        end
    end

    // Count cycles in which neither stream moves a transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : watchdog
        wait (idle_cycles >= IDLE_LIMIT);
        $display("i2c_bit_level_master verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result sink: random stalls per transfer, plus one long hold on request
    // ------------------------------------------------------------------

    initial begin : result_sink
        int gap;
        m_axis_tready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold_cycles > 0) begin
                gap            = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                gap = rx_gaps_on ? $urandom_range(0, GAP_MAX) : 0;
            end
            // lower ready only when a stall is due, so back-to-back transfers keep it high
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one tick and predict its result once the transfer happens.
    // Valid stays high on return; wait_drained drops it, as does the next call before a gap.
    task automatic send_tick(input logic [2:0] req, input logic [7:0] wr, input logic sda_in);
        int gap;
        gap = tx_gaps_on ? $urandom_range(0, GAP_MAX) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {{(IN_DATA_W-9){1'b0}}, sda_in, wr};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_lines.push_back(tick_bus(req, wr, sda_in));
        items_sent++;
    endtask

    // Drop valid and wait until every predicted result has come out.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_lines.size() != 0) @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // Write ticks_per_unit (junk in the upper half), then read it back.
    task automatic write_unit_len(input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_TPU;
        pwdata  <= {16'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        unit_len_reg = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[15:0] !== value) note_mismatch("ticks_per_unit readback", value, prdata[15:0]);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Tick the running command to its end. Busy ticks carry random commands
    // that must be dropped; the done tick always carries a real one. For a
    // read, data gives the level of SDA held through each bit, MSB first.
    task automatic finish_command(input logic [7:0] data);
        logic [2:0] req;
        logic       sda_in;
        while (bus.cmd != CMD_NONE) begin
            if (finishes_next())
                req = 3'($urandom_range(CMD_START, CMD_NACK));
            else
                req = 3'($urandom_range(CMD_NONE, REQ_UNUSED));
            sda_in = (bus.cmd == CMD_READ) ? data[3'd7 - bus.bit_idx[2:0]] : 1'($urandom);
            send_tick(req, 8'($urandom), sda_in);
        end
    endtask

    task automatic run_command(input logic [2:0] cmd, input logic [7:0] data);
        send_tick(cmd, data, 1'($urandom));
        finish_command(data);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Idle ticks show released lines; a start then runs at the reset unit length.
    task automatic test_reset_unit();
        send_tick(CMD_NONE, 8'h00, 1'b0);
        send_tick(REQ_UNUSED, 8'hFF, 1'b1);
        run_command(CMD_START, 8'h00);
        wait_drained();
    endtask

    // Every command once at the shortest unit, with mixed data bits.
    task automatic test_each_command();
        write_unit_len(16'd1);
        run_command(CMD_START, 8'h00);
        run_command(CMD_WRITE, 8'hA5);
        run_command(CMD_READ, 8'h5A);
        run_command(CMD_ACK, 8'h00);
        run_command(CMD_NACK, 8'hFF);
        run_command(CMD_STOP, 8'h00);
        send_tick(REQ_UNUSED, 8'h81, 1'b0);
        send_tick(CMD_NONE, 8'h7E, 1'b1);
        wait_drained();
    endtask

    // Zero unit length, full-scale register readback, and a unit change in mid command.
    task automatic test_unit_extremes();
        write_unit_len(16'd0);
        run_command(CMD_ACK, 8'h00);
        wait_drained();
        write_unit_len(16'hFFFF);
        // the new length takes effect from the next segment of the start
        write_unit_len(16'd3);
        send_tick(CMD_START, 8'h00, 1'b1);
        send_tick(CMD_NONE, 8'h00, 1'b0);
        send_tick(CMD_NONE, 8'h00, 1'b1);
        wait_drained();
        write_unit_len(16'd1);
        finish_command(8'h00);
        wait_drained();
    endtask

    // Random command streams with random unit lengths and gap patterns.
    task automatic test_random_traffic();
        int first;
        int cmds;
        first = items_sent;
        cmds  = 0;
        while (items_sent - first < RANDOM_ITEMS) begin
            if (cmds % 8 == 0) begin
                wait_drained();
                write_unit_len(16'($urandom_range(1, 3)));
            end
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_gaps_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(0, 2)) begin
                send_tick($urandom_range(0, 1) ? 3'(CMD_NONE) : REQ_UNUSED,
                          8'($urandom), 1'($urandom));
            end
            run_command(3'($urandom_range(CMD_START, CMD_NACK)), 8'($urandom));
            cmds++;
        end
        wait_drained();
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
    endtask

    // Hold the sink off for a long stretch while ticks keep coming, so the
    // skid stage fills and the input stalls.
    task automatic test_output_stall();
        write_unit_len(16'd1);
        tx_gaps_on     = 1'b0;
        rx_hold_cycles = HOLD_CYCLES;
        run_command(CMD_WRITE, 8'hC3);
        run_command(CMD_READ, 8'h96);
        wait_drained();
        tx_gaps_on = 1'b1;
    endtask

    initial begin
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = CMD_NONE;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        tx_gaps_on     = 1'b1;
        rx_gaps_on     = 1'b1;
        rx_hold_cycles = 0;
        items_sent     = 0;
        results_seen   = 0;
        mismatches     = 0;
        idle_cycles    = 0;
        unit_len_reg   = TPU_RESET;
        bus            = '{cmd: CMD_NONE, phase: 4'd0, ticks: 18'd0, bit_idx: 4'd0,
                           shreg: 8'h00, scl: 1'b1, sda: 1'b1};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_unit();
        test_each_command();
        test_unit_extremes();
        test_random_traffic();
        test_output_stall();

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("i2c_bit_level_master verification clean");
        else
            $display("i2c_bit_level_master verification failed");
        $finish;
    end

endmodule
